/* hw/rtl/tlic_pkg.sv */
// Shared types, constants and CRC helpers for the thermal line integrity checker.
package tlic_pkg;

   localparam int SAMPLE_W = 14;
   localparam int CRC_W    = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;

   localparam int PIXELS_PER_LINE_DEF = 80;
   localparam int LINES_PER_FRAME_DEF = 32;

   localparam logic [CRC_W-1:0] CRC_POLY = 8'h07;
   localparam logic [CRC_W-1:0] CRC_INIT = 8'h00;

   // Input transaction fields
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_value;
      logic                parity_flag;
      logic [CRC_W-1:0]    expected_line_crc;
      logic                frame_start;
   } req_payload_type;

   // Result transaction fields
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic                parity_good;
      logic                line_end;
      logic                crc_good;
      logic [ROW_W-1:0]    row_index;
      logic [COL_W-1:0]    column_index;
      logic                frame_end;
      logic                frame_good;
   } rsp_payload_type;

   // Pipeline flow control between the input stage and the check stage
   typedef struct packed {
      logic valid;
      logic advance;
   } flow_type;

   // Shift one byte through the CRC-8, MSB first, no reflection
   function automatic logic [CRC_W-1:0] crc8_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0]       data);
      logic [CRC_W-1:0] v;
      v = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (v[CRC_W-1]) begin
            v = {v[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[CRC_W-2:0], 1'b0};
         end
      end
      return v;
   endfunction

   // Feed a pixel as two bytes, high byte first
   function automatic logic [CRC_W-1:0] crc8_pixel(input logic [CRC_W-1:0]    crc,
                                                   input logic [SAMPLE_W-1:0] sample);
      logic [15:0]      word;
      logic [CRC_W-1:0] mid;
      word = {{(16 - SAMPLE_W){1'b0}}, sample};
      mid  = crc8_byte(crc, word[15:8]);
      return crc8_byte(mid, word[7:0]);
   endfunction

endpackage

/* hw/rtl/thermal_line_integrity_checker_core.sv */
// Top level of the thermal line integrity checker: input register, check stage, result register.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------
//   request  | req_valid / req_stall | req_payload (req_payload_type)
//   response | rsp_valid / rsp_stall | rsp_payload (rsp_payload_type)
//
// One transaction per cycle while rsp_stall is low; each crosses input, then result register.
// Parity and two-byte CRC-8 update are combinational between the input and result registers.
// Reset (synchronous) empties both registers and clears the CRC, counters and error flag.
// rsp_stall holds the result register; req_stall rises only when both registers are full
// and rsp_stall holds the result.
module thermal_line_integrity_checker_core #(
   parameter int PIXELS_PER_LINE = tlic_pkg::PIXELS_PER_LINE_DEF,
   parameter int LINES_PER_FRAME = tlic_pkg::LINES_PER_FRAME_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tlic_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tlic_pkg::rsp_payload_type rsp_payload
);

   localparam logic [tlic_pkg::COL_W-1:0] LAST_COL = tlic_pkg::COL_W'(PIXELS_PER_LINE - 1);

   tlic_pkg::flow_type        flow;
   tlic_pkg::req_payload_type item;
   tlic_pkg::rsp_payload_type result;
   logic                      out_ready;

   tlic_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .down_ready  (out_ready),
      .flow        (flow),
      .item        (item)
   );

   tlic_check #(
      .PIXELS_PER_LINE (PIXELS_PER_LINE),
      .LINES_PER_FRAME (LINES_PER_FRAME)
   ) u_check (
      .clock  (clock),
      .reset  (reset),
      .flow   (flow),
      .item   (item),
      .result (result)
   );

   tlic_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (flow.advance),
      .result      (result),
      .ready       (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Frame verdict only on the frame's last pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_good |-> rsp_payload.frame_end)
      else $error("frame_good without frame_end");

   // Frame end is always a line end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_end |-> rsp_payload.line_end)
      else $error("frame_end without line_end");

   // CRC can only fail at a line end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.line_end |-> rsp_payload.crc_good)
      else $error("crc failure off line end");

   // Column count stays within the line
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.column_index <= LAST_COL)
      else $error("column index past end of line");

endmodule

/* hw/rtl/tlic_in_stage.sv */
// Input register stage: captures request transactions and holds them for the check stage.
module tlic_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tlic_pkg::req_payload_type req_payload,
   input  logic                      down_ready,
   output tlic_pkg::flow_type        flow,
   output tlic_pkg::req_payload_type item
);

   logic                      valid_ff;
   logic                      valid_in;
   tlic_pkg::req_payload_type data_ff;
   logic                      accept;
   logic                      advance;

   // Move the held transaction on when the check stage can take it
   assign advance   = valid_ff && down_ready;
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on each accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_payload;
      end
   end

   assign flow.valid   = valid_ff;
   assign flow.advance = advance;
   assign item         = data_ff;

endmodule

/* hw/rtl/tlic_check.sv */
// Line/frame state and the single-pass parity and CRC check for one pixel.
module tlic_check #(
   parameter int PIXELS_PER_LINE = tlic_pkg::PIXELS_PER_LINE_DEF,
   parameter int LINES_PER_FRAME = tlic_pkg::LINES_PER_FRAME_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tlic_pkg::flow_type        flow,
   input  tlic_pkg::req_payload_type item,
   output tlic_pkg::rsp_payload_type result
);

   localparam logic [tlic_pkg::COL_W-1:0] LAST_COL = tlic_pkg::COL_W'(PIXELS_PER_LINE - 1);
   localparam logic [tlic_pkg::ROW_W-1:0] LAST_ROW = tlic_pkg::ROW_W'(LINES_PER_FRAME - 1);

   logic [tlic_pkg::CRC_W-1:0] crc_ff, crc_in;
   logic [tlic_pkg::COL_W-1:0] col_ff, col_in;
   logic [tlic_pkg::ROW_W-1:0] row_ff, row_in;
   logic                       err_ff, err_in;

   logic [tlic_pkg::CRC_W-1:0] crc_base, crc_new;
   logic [tlic_pkg::COL_W-1:0] col_cur;
   logic [tlic_pkg::ROW_W-1:0] row_cur;
   logic                       err_cur, err_now;
   logic                       par_ok, crc_ok, line_end, frame_end;

   // Drop accumulated state at start of frame
   assign crc_base = item.frame_start ? tlic_pkg::CRC_INIT : crc_ff;
   assign col_cur  = item.frame_start ? '0 : col_ff;
   assign row_cur  = item.frame_start ? '0 : row_ff;
   assign err_cur  = item.frame_start ? 1'b0 : err_ff;

   // Odd parity over sample plus parity bit
   assign par_ok  = ^{item.sample_value, item.parity_flag};
   assign crc_new = tlic_pkg::crc8_pixel(crc_base, item.sample_value);

   assign line_end  = (col_cur >= LAST_COL);
   assign frame_end = line_end && (row_cur >= LAST_ROW);
   assign crc_ok    = line_end ? (crc_new == item.expected_line_crc) : 1'b1;
   assign err_now   = err_cur || !par_ok || !crc_ok;

   // Advance counters, CRC and error flag; wrap at line and frame end
   always_comb begin
      crc_in = crc_new;
      col_in = col_cur + 1'b1;
      row_in = row_cur;
      err_in = err_now;
      if (line_end) begin
         crc_in = tlic_pkg::CRC_INIT;
         col_in = '0;
         if (frame_end) begin
            row_in = '0;
            err_in = 1'b0;
         end else begin
            row_in = row_cur + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= tlic_pkg::CRC_INIT;
         col_ff <= '0;
         row_ff <= '0;
         err_ff <= 1'b0;
      end else if (flow.advance) begin
         crc_ff <= crc_in;
         col_ff <= col_in;
         row_ff <= row_in;
         err_ff <= err_in;
      end
   end

   always_comb begin
      result.sample_out   = item.sample_value;
      result.parity_good  = par_ok;
      result.line_end     = line_end;
      result.crc_good     = crc_ok;
      result.row_index    = row_cur;
      result.column_index = col_cur;
      result.frame_end    = frame_end;
      result.frame_good   = frame_end && !err_now;
   end

endmodule

/* hw/rtl/tlic_out_stage.sv */
// Result register stage: holds a finished transaction until the receiver takes it.
module tlic_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  tlic_pkg::rsp_payload_type result,
   output logic                      ready,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tlic_pkg::rsp_payload_type rsp_payload
);

   logic                      valid_ff;
   logic                      valid_in;
   tlic_pkg::rsp_payload_type data_ff;

   // Free when empty or when the held transaction leaves this cycle
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the thermal line integrity checker core.
`timescale 1ns / 100ps

module tb_top;

   localparam int LINE_PIXELS  = tlic_pkg::PIXELS_PER_LINE_DEF;
   localparam int FRAME_LINES  = tlic_pkg::LINES_PER_FRAME_DEF;
   localparam int SETTLE_CYCLES = 10;

   // Track line CRC, position and frame error flag; queue the expected results
   class line_integrity_model;
      tlic_pkg::rsp_payload_type      expected_pixels[$];
      logic [tlic_pkg::CRC_W-1:0]     line_crc;
      logic [tlic_pkg::COL_W-1:0]     col;
      logic [tlic_pkg::ROW_W-1:0]     row;
      bit                             frame_err;
      int                             errors;

      function new();
         line_crc  = '0;
         col       = '0;
         row       = '0;
         frame_err = 1'b0;
         errors    = 0;
      endfunction

      // Shift the pixel through the CRC bit by bit, high byte first
      function logic [tlic_pkg::CRC_W-1:0] pixel_crc(
         input logic [tlic_pkg::CRC_W-1:0]    crc,
         input logic [tlic_pkg::SAMPLE_W-1:0] sample);
         logic [tlic_pkg::CRC_W-1:0] c;
         logic [15:0]                word;
         c    = crc;
         word = {2'b00, sample};
         for (int i = 15; i >= 0; i--) begin
            if (c[tlic_pkg::CRC_W-1] ^ word[i]) begin
               c = {c[tlic_pkg::CRC_W-2:0], 1'b0} ^ tlic_pkg::CRC_POLY;
            end else begin
               c = {c[tlic_pkg::CRC_W-2:0], 1'b0};
            end
         end
         return c;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Predict the result of one accepted transaction and advance the state
      function void note_pixel(input tlic_pkg::req_payload_type p);
         tlic_pkg::rsp_payload_type  r;
         logic [tlic_pkg::CRC_W-1:0] next_crc;
         bit                         last_col;
         bit                         last_row;
         if (p.frame_start) begin
            line_crc  = '0;
            col       = '0;
            row       = '0;
            frame_err = 1'b0;
         end
         next_crc = pixel_crc(line_crc, p.sample_value);
         last_col = (col >= LINE_PIXELS - 1);
         last_row = last_col && (row >= FRAME_LINES - 1);
         r.sample_out   = p.sample_value;
         r.parity_good  = ^{p.sample_value, p.parity_flag};
         r.line_end     = last_col;
         r.crc_good     = last_col ? (next_crc == p.expected_line_crc) : 1'b1;
         r.row_index    = row;
         r.column_index = col;
         r.frame_end    = last_row;
         if (!r.parity_good || !r.crc_good) begin
            frame_err = 1'b1;
         end
         r.frame_good = last_row ? !frame_err : 1'b0;
         expected_pixels.push_back(r);
         // Restart the CRC per line; wrap row and error flag at frame end
         if (last_col) begin
            line_crc = '0;
            col      = '0;
            if (last_row) begin
               row       = '0;
               frame_err = 1'b0;
            end else begin
               row = row + 1'b1;
            end
         end else begin
            line_crc = next_crc;
            col      = col + 1'b1;
         end
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // Compare a result transaction with the oldest expectation
      function void check_result(input tlic_pkg::rsp_payload_type got);
         tlic_pkg::rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            $display("[%0t] unexpected result: expected none, actual %0h", $time, got);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         check_field("sample_out",   want.sample_out,   got.sample_out);
         check_field("parity_good",  want.parity_good,  got.parity_good);
         check_field("line_end",     want.line_end,     got.line_end);
         check_field("crc_good",     want.crc_good,     got.crc_good);
         check_field("row_index",    want.row_index,    got.row_index);
         check_field("column_index", want.column_index, got.column_index);
         check_field("frame_end",    want.frame_end,    got.frame_end);
         check_field("frame_good",   want.frame_good,   got.frame_good);
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   tlic_pkg::req_payload_type req_payload;
   logic                      rsp_valid;
   logic                      rsp_stall;
   tlic_pkg::rsp_payload_type rsp_payload;

   line_integrity_model board;
   int send_idle_pct    = 0;
   int recv_idle_pct    = 0;
   int stall_burst_req  = 0;
   int stall_burst_left = 0;

   thermal_line_integrity_checker_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // End the run if it hangs
   initial begin
      #2000000;
      $display("thermal_line_integrity_checker_core regression: fail");
      $finish;
   end

   // Receive result transactions; stall at random or for a requested burst
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            board.check_result(rsp_payload);
         end
         if (stall_burst_left == 0 && stall_burst_req > 0) begin
            stall_burst_left = stall_burst_req;
            stall_burst_req  = 0;
         end
         if (stall_burst_left > 0) begin
            rsp_stall <= 1'b1;
            stall_burst_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic tlic_pkg::req_payload_type make_pixel(
      logic [tlic_pkg::SAMPLE_W-1:0] sample, logic pflag,
      logic [tlic_pkg::CRC_W-1:0] crc, logic fstart);
      tlic_pkg::req_payload_type p;
      p.sample_value      = sample;
      p.parity_flag       = pflag;
      p.expected_line_crc = crc;
      p.frame_start       = fstart;
      return p;
   endfunction

   // Offer one transaction after a random gap; hold it until accepted
   task automatic send_pixel(input tlic_pkg::req_payload_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_pixel(p);
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Send well-formed lines; inject parity errors at the given rate and CRC errors at four times it
   task automatic send_frame(input bit mark_start, input int n_lines, input int err_pct);
      logic [tlic_pkg::CRC_W-1:0] run_crc;
      tlic_pkg::req_payload_type  p;
      run_crc = '0;
      for (int r = 0; r < n_lines; r++) begin
         for (int c = 0; c < LINE_PIXELS; c++) begin
            case ($urandom_range(9))
               0:       p.sample_value = '0;
               1:       p.sample_value = '1;
               default: p.sample_value = tlic_pkg::SAMPLE_W'($urandom_range(0, 16383));
            endcase
            p.parity_flag = ~(^p.sample_value);
            if ($urandom_range(99) < err_pct) begin
               p.parity_flag = ~p.parity_flag;
            end
            p.frame_start = mark_start && (r == 0) && (c == 0);
            run_crc = board.pixel_crc(run_crc, p.sample_value);
            if (c == LINE_PIXELS - 1) begin
               p.expected_line_crc = run_crc;
               if ($urandom_range(99) < 4 * err_pct) begin
                  p.expected_line_crc ^= tlic_pkg::CRC_W'($urandom_range(1, 255));
               end
               run_crc = '0;
            end else begin
               p.expected_line_crc = tlic_pkg::CRC_W'($urandom_range(0, 255));
            end
            send_pixel(p);
         end
      end
   endtask

   // Send unstructured transactions with occasional frame starts
   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++) begin
         send_pixel(make_pixel(tlic_pkg::SAMPLE_W'($urandom_range(0, 16383)),
                               1'($urandom_range(1)),
                               tlic_pkg::CRC_W'($urandom_range(0, 255)),
                               ($urandom_range(99) < 3)));
      end
   endtask

   initial begin
      board       = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Sender sparse, receiver mostly stalled
      send_idle_pct = 36;
      recv_idle_pct = 77;

      // Directed: field extremes, both parity outcomes, frame start mid-frame
      send_pixel(make_pixel(14'h0000, 1'b1, 8'h00, 1'b1));
      send_pixel(make_pixel(14'h3fff, 1'b0, 8'hff, 1'b0));
      send_pixel(make_pixel(14'h3fff, 1'b1, 8'h00, 1'b0));
      send_pixel(make_pixel(14'h0000, 1'b0, 8'hff, 1'b0));
      send_pixel(make_pixel(14'h2aaa, 1'b1, 8'h55, 1'b0));
      send_pixel(make_pixel(14'h1555, 1'b0, 8'haa, 1'b1));
      send_pixel(make_pixel(14'h2000, 1'b1, 8'h80, 1'b0));
      send_pixel(make_pixel(14'h0001, 1'b0, 8'h01, 1'b0));
      send_pixel(make_pixel(14'h0000, 1'b1, 8'h00, 1'b1));
      send_pixel(make_pixel(14'h0000, 1'b1, 8'h00, 1'b1));
      send_pixel(make_pixel(14'h3ffe, 1'b0, 8'h7f, 1'b0));
      send_pixel(make_pixel(14'h1fff, 1'b1, 8'hfe, 1'b0));
      drain_results();

      // Several lines with a few errors, ending aligned on a line boundary
      send_frame(1'b1, 4, 1);
      drain_results();

      // Swap idling; clean lines continuing the frame without a frame start
      send_idle_pct = 77;
      recv_idle_pct = 36;
      send_frame(1'b0, 3, 0);
      send_noise(150);

      // No idling: partial frames, a long receiver hold-off and more noise
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_frame(1'b1, 2, 5);
      stall_burst_req = 60;
      send_frame(1'b1, 2, 5);
      drain_results();
      send_noise(100);
      send_frame(1'b1, 1, 0);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("thermal_line_integrity_checker_core regression: pass");
      end else begin
         $display("thermal_line_integrity_checker_core regression: fail");
      end
      $finish;
   end

endmodule
